// ===== rtl/core/shs_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher.
// Holds the round constant table, the initial hash and the queue entry types.
// No dependencies.
`default_nettype none

package shs_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int DIGEST_WORDS = 8;
    localparam int BLOCK_WORDS  = 16;
    localparam int COUNT_W      = 61;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,
        OP_BYTE_END = 2'd1,
        OP_END      = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_item;

    // front -> queue write side
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_wr;

    // queue -> back read side
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_rd;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_PAD   = 3'd1,
        S_LEN   = 3'd2,
        S_LOAD  = 3'd3,
        S_ROUND = 3'd4,
        S_ADD   = 3'd5,
        S_OUT   = 3'd6
    } t_state;

    typedef enum logic [1:0] {
        PH_DATA      = 2'd0,
        PH_PAD_FIRST = 2'd1,
        PH_PAD_LAST  = 2'd2
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/core/shs_front.sv =====
// Input side of the hasher: takes stream transactions and classifies them.
// Drops items that carry neither a byte nor an end mark. Uses shs_pkg.
`default_nettype none

module shs_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire  [7:0]       i_s_axis_tdata,
    input  wire              i_s_axis_tuser,
    input  wire              i_s_axis_tlast,
    output shs_pkg::t_q_wr   o_wr,
    input  wire              i_q_full
);
    import shs_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;
    t_item n_item;
    logic  w_keep;
    logic  w_push;

    assign w_push          = r_valid && !i_q_full;
    assign o_s_axis_tready = !r_valid || !i_q_full;
    assign w_keep          = i_s_axis_tuser || i_s_axis_tlast;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (w_push) begin
            n_valid = 1'b0;
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            n_valid     = w_keep;
            n_item.data = i_s_axis_tdata;
            if (i_s_axis_tuser && i_s_axis_tlast) begin
                n_item.op = OP_BYTE_END;
            end else if (i_s_axis_tuser) begin
                n_item.op = OP_BYTE;
            end else begin
                n_item.op = OP_END;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_wr.valid = w_push;
    assign o_wr.item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/core/shs_queue.sv =====
// Small FIFO between the classifying front and the hashing back.
// Register array with one write and one read port. Uses shs_pkg.
`default_nettype none

module shs_queue #(
    parameter int DEPTH = shs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  shs_pkg::t_q_wr  i_wr,
    output logic            o_full,
    output shs_pkg::t_q_rd  o_rd,
    input  wire             i_pop
);
    import shs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.item  = r_mem[r_rptr];
    assign w_push     = i_wr.valid && !o_full;
    assign w_pop      = i_pop && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wr.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/shs_core.sv =====
// Back end of the hasher: packs bytes into the block, pads, runs the
// 64-round compression one round per cycle and shifts out the digest.
// Uses shs_pkg.
`default_nettype none

module shs_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  shs_pkg::t_q_rd   i_rd,
    output logic             o_pop,
    output logic             o_m_axis_tvalid,
    input  wire              i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast
);
    import shs_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    t_state             r_state;
    t_state             n_state;
    t_phase             r_phase;
    logic               r_end_pend;
    logic [5:0]         r_rnd;
    logic [2:0]         r_oidx;
    logic [COUNT_W-1:0] r_cnt;
    logic [31:0]        r_hash [DIGEST_WORDS];
    logic [31:0]        r_blk  [BLOCK_WORDS];
    logic [31:0]        r_w    [BLOCK_WORDS];
    logic [31:0]        r_v    [8];

    logic [5:0]         w_pos;
    logic [63:0]        w_len_bits;
    logic [31:0]        w_padded [BLOCK_WORDS];
    logic               w_take;
    logic               w_has_byte;
    logic               w_has_end;
    logic               w_out_hs;
    logic [31:0]        w_sched;
    logic [31:0]        w_t1;
    logic [31:0]        w_t2;

    assign w_pos      = r_cnt[5:0];
    assign w_len_bits = {r_cnt, 3'b000};
    assign w_has_byte = (i_rd.item.op == OP_BYTE) || (i_rd.item.op == OP_BYTE_END);
    assign w_has_end  = (i_rd.item.op == OP_BYTE_END) || (i_rd.item.op == OP_END);
    assign w_take     = (r_state == S_IDLE) && i_rd.valid;
    assign w_out_hs   = o_m_axis_tvalid && i_m_axis_tready;

    // 0x80 at the current position, zeros after it
    always_comb begin
        logic [5:0] q;
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            for (int j = 0; j < 4; j++) begin
                q = 6'(4 * i + j);
                if (q == w_pos) begin
                    w_padded[i][8*(3-j) +: 8] = PAD_BYTE;
                end else if (q > w_pos) begin
                    w_padded[i][8*(3-j) +: 8] = 8'h00;
                end else begin
                    w_padded[i][8*(3-j) +: 8] = r_blk[i][8*(3-j) +: 8];
                end
            end
        end
    end

    assign w_sched = (rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10))
                   + r_w[9]
                   + (rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3))
                   + r_w[0];

    assign w_t1 = r_v[7]
                + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + ROUND_K[r_rnd] + r_w[0];
    assign w_t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        n_state         = r_state;
        o_pop           = 1'b0;
        o_m_axis_tvalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_rd.valid) begin
                    o_pop = 1'b1;
                    if (w_has_byte && (w_pos == 6'd63)) begin
                        n_state = S_LOAD;
                    end else if (w_has_end) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD:   n_state = S_LOAD;
            S_LEN:   n_state = S_LOAD;
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: begin
                if (r_rnd == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                case (r_phase)
                    PH_DATA:      n_state = r_end_pend ? S_PAD : S_IDLE;
                    PH_PAD_FIRST: n_state = S_LEN;
                    PH_PAD_LAST:  n_state = S_OUT;
                    default:      n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready && (r_oidx == 3'd7)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DATA;
            r_end_pend <= 1'b0;
            r_rnd      <= '0;
            r_oidx     <= '0;
            r_cnt      <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_hash[i] <= INIT_HASH[i];
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_phase    <= PH_DATA;
                        r_end_pend <= w_has_end;
                        if (w_has_byte) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_PAD: begin
                    r_end_pend <= 1'b0;
                    r_phase    <= (w_pos >= 6'd56) ? PH_PAD_FIRST : PH_PAD_LAST;
                end
                S_LEN:  r_phase <= PH_PAD_LAST;
                S_LOAD: r_rnd   <= '0;
                S_ROUND: r_rnd  <= r_rnd + 1'b1;
                S_ADD: begin
                    r_oidx <= '0;
                    for (int i = 0; i < DIGEST_WORDS; i++) begin
                        r_hash[i] <= r_hash[i] + r_v[i];
                    end
                end
                S_OUT: begin
                    // shift the digest out; the initial hash refills from the top
                    if (w_out_hs) begin
                        for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                            r_hash[i] <= r_hash[i+1];
                        end
                        r_hash[DIGEST_WORDS-1] <= INIT_HASH[r_oidx];
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            r_cnt <= '0;
                        end
                    end
                end
                default: r_rnd <= r_rnd;
            endcase
        end
    end

    // block, schedule and working variables
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_take && w_has_byte) begin
                    r_blk[w_pos[5:2]][{~w_pos[1:0], 3'b000} +: 8] <= i_rd.item.data;
                end
            end
            S_PAD: begin
                for (int i = 0; i < BLOCK_WORDS; i++) begin
                    r_blk[i] <= w_padded[i];
                end
                if (w_pos < 6'd56) begin
                    r_blk[14] <= w_len_bits[63:32];
                    r_blk[15] <= w_len_bits[31:0];
                end
            end
            S_LEN: begin
                for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
                    r_blk[i] <= '0;
                end
                r_blk[14] <= w_len_bits[63:32];
                r_blk[15] <= w_len_bits[31:0];
            end
            S_LOAD: begin
                for (int i = 0; i < BLOCK_WORDS; i++) begin
                    r_w[i] <= r_blk[i];
                end
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_hash[i];
                end
            end
            S_ROUND: begin
                for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[BLOCK_WORDS-1] <= w_sched;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + w_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= w_t1 + w_t2;
            end
            default: r_v[0] <= r_v[0];
        endcase
    end

    assign o_m_axis_tdata = {5'b00000, r_oidx, r_hash[0]};
    assign o_m_axis_tlast = (r_oidx == 3'd7);

endmodule

`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: front classifier, queue, hash core.
// Depends on shs_pkg, shs_front, shs_queue and shs_core.
//
//  channel   | dir | tdata                         | tuser        | tlast
//  s_axis    | in  | [7:0] data_byte               | byte_present | end_of_message
//  m_axis    | out | [31:0] digest_word, [34:32]   | -            | last_word
//            |     | word_index, [39:35] zero      |              |
//
// The core packs the bytes into the block one at a time; a full 64-byte block then
// runs the compression (load, 64 rounds, hash add), during which no byte is taken.
// An end mark adds a padding step and a final block; a spilled length adds a length
// setup step and a second final block. Eight digest words leave one per ready cycle.
// Synchronous active-low reset loads the initial hash and clears the count.
// The queue lets the front keep accepting while the core hashes or stalls, until it is full.
`default_nettype none

module sha256_stream_hasher #(
    parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tuser,   // [0] byte_present
    input  wire         i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_axis_tlast
);
    import shs_pkg::*;

    t_q_wr w_wr;
    t_q_rd w_rd;
    logic  w_full;
    logic  w_pop;

    shs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_wr            (w_wr),
        .i_q_full        (w_full)
    );

    shs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_full  (w_full),
        .o_rd    (w_rd),
        .i_pop   (w_pop)
    );

    shs_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rd            (w_rd),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // no new item enters the core while a digest is being delivered
    ap_no_pop_during_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !w_pop)
        else $error("queue popped while digest output active");

    // digest words come out in order
    ap_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
        (o_m_axis_tvalid && (o_m_axis_tdata[34:32] == $past(o_m_axis_tdata[34:32]) + 3'd1)))
        else $error("digest word index did not advance");

    // output valid drops after the last digest word
    ap_digest_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> !o_m_axis_tvalid)
        else $error("output still valid after the last digest word");

endmodule

`default_nettype wire
